@@ rtl/core/zncc_best_reference_frame_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the reference frame matcher
// Concurrent checks on the block's own control logic, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ZNCC_BEST_REFERENCE_FRAME_ASSERT_SVH
`define ZNCC_BEST_REFERENCE_FRAME_ASSERT_SVH
`ifndef SYNTHESIS
`define ZBRF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zbrf: same-cycle check failed");
`define ZBRF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zbrf: next-cycle check failed");
`else
`define ZBRF_ASSERT_IMP(label, ante, cons)
`define ZBRF_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ rtl/core/zbrf_pkg.sv @@
// ----------------------------------------------------------------------------
// Reference frame matcher package
// Field widths, constants and the command and status words between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package zbrf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SLOT_W   = 3;
    localparam int INDEX_W  = 9;
    localparam int THR_W    = 10;
    localparam int KMAX_W   = 4;
    localparam int SCALE_W  = 20;

    localparam logic [THR_W-1:0]   THR_RESET       = 10'd200;
    localparam logic [SCALE_W-1:0] PER_MILLE_SCALE = 20'd1000000;

    typedef enum logic [2:0] {
        MUL_CC     = 3'd0,
        MUL_SQ_BR  = 3'd1,
        MUL_BB     = 3'd2,
        MUL_SQ_R   = 3'd3,
        MUL_SQ_SC  = 3'd4,
        MUL_TT     = 3'd5,
        MUL_SQ_M   = 3'd6,
        MUL_RHS_BR = 3'd7
    } mul_op_t;

    typedef struct packed {
        logic              clear_en;
        logic              mac_rd;
        logic              mic_update;
        logic              calc_m;
        logic              calc_mv;
        logic              calc_p;
        logic              calc_cr;
        logic              take;
        logic              mul_start;
        mul_op_t           mul_op;
        logic              load_result;
        logic              result_found;
        logic              clear_acc;
        logic [KMAX_W-1:0] k;
    } zbrf_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic count_full;
        logic mul_busy;
        logic mul_done;
        logic candidate;
        logic have;
        logic lhs_gt;
        logic lhs_ge;
        logic out_free;
    } zbrf_status_t;

endpackage

@@ rtl/core/zbrf_if.sv @@
// ----------------------------------------------------------------------------
// Reference frame matcher channels
// Valid/ready channels for the sample words and the result words.
// ----------------------------------------------------------------------------
interface zbrf_sample_if;
    logic              valid;
    logic              ready;
    logic              operation;
    logic [2:0]        slot;
    logic [8:0]        sample_index;
    logic signed [15:0] sample;
    logic              last;

    modport source (output valid, output operation, output slot, output sample_index,
                    output sample, output last, input ready);
    modport sink (input valid, input operation, input slot, input sample_index,
                  input sample, input last, output ready);
endinterface

interface zbrf_result_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [2:0] best_slot;

    modport source (output valid, output found, output best_slot, input ready);
    modport sink (input valid, input found, input best_slot, output ready);
endinterface

@@ rtl/core/zncc_best_reference_frame.sv @@
// ----------------------------------------------------------------------------
// Best reference frame matcher
// Picks the stored reference frame with the highest zero-mean normalised
// cross-correlation against a microphone frame.
// ----------------------------------------------------------------------------
// After reset the block sweeps the reference store to zero, one entry per
// cycle over all HISTORY_FRAMES * FRAME_SAMPLES entries (3072 by default), and
// takes no word until that is done; threshold writes are taken at any time.
// After a reference write the block is ready for another word. A mic word
// keeps ready low until one store read port and one multiply-accumulate have
// served the slots in turn. The word marked last then scores every slot
// through a shared bit-serial multiplier of 3 * VW bits, where VW is about
// 2 * log2(FRAME_SAMPLES) + 34, using at most 4 * HISTORY_FRAMES + 1 products,
// and a result word follows.
module zncc_best_reference_frame
    import zbrf_pkg::*;
#(
    parameter int HISTORY_FRAMES = 6,
    parameter int FRAME_SAMPLES  = 512
)
(
    input  logic             clk,
    input  logic             rst_n,
    zbrf_sample_if.sink      sample_ch,
    zbrf_result_if.source    result_ch,
    input  logic             cfg_we,
    input  logic [THR_W-1:0] cfg_wdata
);

    zbrf_cmd_t    cmd;
    zbrf_status_t status;
    logic         in_ready;
    logic         accept;

    assign sample_ch.ready = in_ready;
    assign accept          = sample_ch.valid && in_ready;

    zbrf_controller
    #(
        .HISTORY_FRAMES (HISTORY_FRAMES)
    )
    u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_ch.valid),
        .in_op    (sample_ch.operation),
        .in_last  (sample_ch.last),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    zbrf_datapath
    #(
        .HISTORY_FRAMES (HISTORY_FRAMES),
        .FRAME_SAMPLES  (FRAME_SAMPLES)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_op         (sample_ch.operation),
        .in_slot       (sample_ch.slot),
        .in_index      (sample_ch.sample_index),
        .in_sample     (sample_ch.sample),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (result_ch.ready),
        .out_valid     (result_ch.valid),
        .out_found     (result_ch.found),
        .out_best_slot (result_ch.best_slot)
    );

endmodule

@@ rtl/core/zbrf_serial_mul.sv @@
// ----------------------------------------------------------------------------
// Serial multiplier
// Unsigned shift-and-add multiplier, one bit of the multiplier per cycle.
// ----------------------------------------------------------------------------
module zbrf_serial_mul
#(
    parameter int A_W = 126,
    parameter int B_W = 42
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    output logic           busy,
    output logic           done,
    output logic [A_W-1:0] product
);

    localparam int CW = $clog2(B_W + 1);

    logic [A_W-1:0] a_reg;
    logic [B_W-1:0] b_reg;
    logic [A_W-1:0] acc_reg;
    logic [CW-1:0]  cnt_reg;
    logic           done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(B_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign busy    = (cnt_reg != '0);
    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ rtl/core/zbrf_datapath.sv @@
// ----------------------------------------------------------------------------
// Reference frame matcher datapath
// Reference store, accumulators, variance terms, comparison products and the
// result register.
// ----------------------------------------------------------------------------
`include "zncc_best_reference_frame_assert.svh"

module zbrf_datapath
    import zbrf_pkg::*;
#(
    parameter int HISTORY_FRAMES = 6,
    parameter int FRAME_SAMPLES  = 512
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic                       in_op,
    input  logic [SLOT_W-1:0]          in_slot,
    input  logic [INDEX_W-1:0]         in_index,
    input  logic signed [SAMPLE_W-1:0] in_sample,
    input  logic                       cfg_we,
    input  logic [THR_W-1:0]           cfg_wdata,
    input  zbrf_cmd_t                  cmd,
    output zbrf_status_t               status,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic                       out_found,
    output logic [SLOT_W-1:0]          out_best_slot
);

    localparam int DEPTH = HISTORY_FRAMES * FRAME_SAMPLES;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(HISTORY_FRAMES);
    localparam int NW    = $clog2(FRAME_SAMPLES + 1);
    localparam int SUMW  = 17 + $clog2(FRAME_SAMPLES);
    localparam int SQW   = 32 + $clog2(FRAME_SAMPLES);
    localparam int VW    = NW + SQW + 1;
    localparam int PW    = 3 * VW;

    logic signed [SAMPLE_W-1:0] ref_mem [DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic [AW-1:0]              clr_addr_reg;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic signed [SAMPLE_W-1:0] mem_wdata;
    logic [AW-1:0]              rd_addr;

    logic [THR_W-1:0]           thr_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       acc_v_reg;
    logic [KW-1:0]              acc_k_reg;
    logic [KW-1:0]              arr_idx;

    logic [NW-1:0]              count_reg;
    logic signed [SUMW-1:0]     mic_sum_reg;
    logic signed [SQW-1:0]      mic_sq_reg;
    logic signed [SUMW-1:0]     ref_sum_reg   [HISTORY_FRAMES];
    logic signed [SQW-1:0]      ref_sq_reg    [HISTORY_FRAMES];
    logic signed [SQW-1:0]      cross_reg     [HISTORY_FRAMES];

    logic signed [31:0]         ref_prod;
    logic signed [31:0]         cross_prod;
    logic signed [31:0]         mic_prod;

    logic signed [VW-1:0]       mterm1_reg;
    logic signed [VW-1:0]       mterm2_reg;
    logic signed [VW-1:0]       p1_reg;
    logic signed [VW-1:0]       p2_reg;
    logic signed [VW-1:0]       q1_reg;
    logic signed [VW-1:0]       q2_reg;
    logic signed [VW-1:0]       c_diff;
    logic signed [VW-1:0]       r_diff;
    logic [VW-1:0]              m_var_reg;
    logic [VW-1:0]              c_abs_reg;
    logic [VW-1:0]              r_var_reg;
    logic [VW-1:0]              bc_reg;
    logic [VW-1:0]              br_reg;
    logic [KW-1:0]              best_k_reg;
    logic                       have_reg;

    logic [PW-1:0]              sq_reg;
    logic [PW-1:0]              lhs_reg;
    logic [PW-1:0]              rhs_reg;
    mul_op_t                    op_reg;
    logic [PW-1:0]              mul_a;
    logic [VW-1:0]              mul_b;
    logic                       mul_busy;
    logic                       mul_done;
    logic [PW-1:0]              mul_product;

    logic                       out_valid_reg;
    logic                       found_reg;
    logic [SLOT_W-1:0]          best_reg;

    // Reference store: writes from the sample channel, zeros during the sweep.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = '0;
        if (cmd.clear_en)
        begin
            mem_we = 1'b1;
        end
        else if (accept && !in_op && (32'(in_slot) < HISTORY_FRAMES)
                 && (32'(in_index) < FRAME_SAMPLES))
        begin
            mem_we    = 1'b1;
            mem_waddr = AW'(32'(in_slot) * FRAME_SAMPLES + 32'(in_index));
            mem_wdata = in_sample;
        end
    end

    assign rd_addr = AW'(32'(cmd.k[KW-1:0]) * FRAME_SAMPLES + 32'(count_reg));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ref_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= ref_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            thr_reg      <= THR_RESET;
            acc_v_reg    <= 1'b0;
            acc_k_reg    <= '0;
        end
        else
        begin
            if (cmd.clear_en)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            acc_v_reg <= cmd.mac_rd;
            acc_k_reg <= cmd.k[KW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= in_sample;
        end
    end

    assign arr_idx    = acc_v_reg ? acc_k_reg : cmd.k[KW-1:0];
    assign ref_prod   = 32'(rd_data_reg) * 32'(rd_data_reg);
    assign cross_prod = 32'(rd_data_reg) * 32'(sample_reg);
    assign mic_prod   = 32'(sample_reg) * 32'(sample_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            mic_sum_reg <= '0;
            mic_sq_reg  <= '0;
            for (int i = 0; i < HISTORY_FRAMES; i++)
            begin
                ref_sum_reg[i] <= '0;
                ref_sq_reg[i]  <= '0;
                cross_reg[i]   <= '0;
            end
        end
        else if (cmd.clear_acc)
        begin
            count_reg   <= '0;
            mic_sum_reg <= '0;
            mic_sq_reg  <= '0;
            for (int i = 0; i < HISTORY_FRAMES; i++)
            begin
                ref_sum_reg[i] <= '0;
                ref_sq_reg[i]  <= '0;
                cross_reg[i]   <= '0;
            end
        end
        else
        begin
            if (acc_v_reg)
            begin
                ref_sum_reg[arr_idx] <= ref_sum_reg[arr_idx] + SUMW'(rd_data_reg);
                ref_sq_reg[arr_idx]  <= ref_sq_reg[arr_idx] + SQW'(ref_prod);
                cross_reg[arr_idx]   <= cross_reg[arr_idx] + SQW'(cross_prod);
            end
            if (cmd.mic_update)
            begin
                count_reg   <= count_reg + 1'b1;
                mic_sum_reg <= mic_sum_reg + SUMW'(sample_reg);
                mic_sq_reg  <= mic_sq_reg + SQW'(mic_prod);
            end
        end
    end

    // Variance and covariance terms, one multiplier stage then one subtract.
    assign c_diff = p1_reg - p2_reg;
    assign r_diff = q1_reg - q2_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.calc_m)
        begin
            mterm1_reg <= $signed(VW'(count_reg)) * VW'(mic_sq_reg);
            mterm2_reg <= VW'(mic_sum_reg) * VW'(mic_sum_reg);
        end
        if (cmd.calc_mv)
        begin
            m_var_reg <= VW'(mterm1_reg - mterm2_reg);
        end
        if (cmd.calc_p)
        begin
            p1_reg <= $signed(VW'(count_reg)) * VW'(cross_reg[arr_idx]);
            p2_reg <= VW'(mic_sum_reg) * VW'(ref_sum_reg[arr_idx]);
            q1_reg <= $signed(VW'(count_reg)) * VW'(ref_sq_reg[arr_idx]);
            q2_reg <= VW'(ref_sum_reg[arr_idx]) * VW'(ref_sum_reg[arr_idx]);
        end
        if (cmd.calc_cr)
        begin
            c_abs_reg <= c_diff[VW-1] ? VW'(-c_diff) : VW'(c_diff);
            r_var_reg <= VW'(r_diff);
        end
        if (cmd.take)
        begin
            bc_reg     <= c_abs_reg;
            br_reg     <= r_var_reg;
            best_k_reg <= cmd.k[KW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else if (cmd.clear_acc)
        begin
            have_reg <= 1'b0;
        end
        else if (cmd.take)
        begin
            have_reg <= 1'b1;
        end
    end

    // Operand selection for the shared serial multiplier.
    always_comb
    begin
        case (cmd.mul_op)
            MUL_CC:
            begin
                mul_a = PW'(c_abs_reg);
                mul_b = c_abs_reg;
            end
            MUL_SQ_BR:
            begin
                mul_a = sq_reg;
                mul_b = br_reg;
            end
            MUL_BB:
            begin
                mul_a = PW'(bc_reg);
                mul_b = bc_reg;
            end
            MUL_SQ_R:
            begin
                mul_a = sq_reg;
                mul_b = r_var_reg;
            end
            MUL_SQ_SC:
            begin
                mul_a = sq_reg;
                mul_b = VW'(PER_MILLE_SCALE);
            end
            MUL_TT:
            begin
                mul_a = PW'(thr_reg);
                mul_b = VW'(thr_reg);
            end
            MUL_SQ_M:
            begin
                mul_a = sq_reg;
                mul_b = m_var_reg;
            end
            MUL_RHS_BR:
            begin
                mul_a = rhs_reg;
                mul_b = br_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    zbrf_serial_mul
    #(
        .A_W (PW),
        .B_W (VW)
    )
    u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_product)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            op_reg <= cmd.mul_op;
        end
        if (mul_done)
        begin
            case (op_reg)
                MUL_CC, MUL_BB, MUL_TT:            sq_reg  <= mul_product;
                MUL_SQ_BR, MUL_SQ_SC:              lhs_reg <= mul_product;
                MUL_SQ_R, MUL_SQ_M, MUL_RHS_BR:    rhs_reg <= mul_product;
                default:                           sq_reg  <= mul_product;
            endcase
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            best_reg      <= '0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
            found_reg     <= cmd.result_found;
            best_reg      <= cmd.result_found ? SLOT_W'(best_k_reg) : '0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_found     = found_reg;
    assign out_best_slot = best_reg;

    assign status.clear_done = cmd.clear_en && (clr_addr_reg == AW'(DEPTH - 1));
    assign status.count_full = (32'(count_reg) >= FRAME_SAMPLES);
    assign status.mul_busy   = mul_busy;
    assign status.mul_done   = mul_done;
    assign status.candidate  = (m_var_reg != '0) && (r_var_reg != '0) && (c_abs_reg != '0);
    assign status.have       = have_reg;
    assign status.lhs_gt     = (lhs_reg > rhs_reg);
    assign status.lhs_ge     = (lhs_reg >= rhs_reg);
    assign status.out_free   = !out_valid_reg || out_ready;

    `ZBRF_ASSERT_IMP(a_not_found_slot_zero, out_valid_reg && !found_reg, best_reg == '0)

endmodule

@@ rtl/core/zbrf_controller.sv @@
// ----------------------------------------------------------------------------
// Reference frame matcher controller
// Sequences the store clearing, the per-sample accumulation and the
// end-of-frame scoring, and issues commands to the datapath.
// ----------------------------------------------------------------------------
`include "zncc_best_reference_frame_assert.svh"

module zbrf_controller
    import zbrf_pkg::*;
#(
    parameter int HISTORY_FRAMES = 6
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_op,
    input  logic         in_last,
    output logic         in_ready,
    input  zbrf_status_t status,
    output zbrf_cmd_t    cmd
);

    localparam int KW = $clog2(HISTORY_FRAMES);
    localparam logic [KW-1:0] K_LAST = KW'(HISTORY_FRAMES - 1);
    localparam logic [2:0] CMP_LAST_STEP = 3'd3;
    localparam logic [2:0] TH_LAST_STEP  = 3'd4;

    typedef enum logic [13:0] {
        ST_CLEAR  = 14'b00000000000001,
        ST_IDLE   = 14'b00000000000010,
        ST_MAC    = 14'b00000000000100,
        ST_DRAIN  = 14'b00000000001000,
        ST_EM1    = 14'b00000000010000,
        ST_EM2    = 14'b00000000100000,
        ST_EP     = 14'b00000001000000,
        ST_ECR    = 14'b00000010000000,
        ST_EDEC   = 14'b00000100000000,
        ST_MSTART = 14'b00001000000000,
        ST_MWAIT  = 14'b00010000000000,
        ST_ECMP   = 14'b00100000000000,
        ST_TCMP   = 14'b01000000000000,
        ST_RESULT = 14'b10000000000000
    } state_t;

    state_t        state_reg, state_next;
    logic [KW-1:0] k_reg, k_next;
    logic [2:0]    step_reg, step_next;
    logic          th_reg, th_next;
    logic          last_reg, last_next;
    logic          found_reg, found_next;
    logic          do_advance;
    logic          accept;

    function automatic mul_op_t cmp_op(input logic [2:0] step);
        case (step)
            3'd0:    return MUL_CC;
            3'd1:    return MUL_SQ_BR;
            3'd2:    return MUL_BB;
            default: return MUL_SQ_R;
        endcase
    endfunction

    function automatic mul_op_t th_op(input logic [2:0] step);
        case (step)
            3'd0:    return MUL_BB;
            3'd1:    return MUL_SQ_SC;
            3'd2:    return MUL_TT;
            3'd3:    return MUL_SQ_M;
            default: return MUL_RHS_BR;
        endcase
    endfunction

    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        step_next  = step_reg;
        th_next    = th_reg;
        last_next  = last_reg;
        found_next = found_reg;
        do_advance = 1'b0;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.mul_op = MUL_CC;
        cmd.k      = KMAX_W'(k_reg);

        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept && in_op)
                begin
                    last_next = in_last;
                    if (status.count_full)
                    begin
                        state_next = in_last ? ST_EM1 : ST_IDLE;
                    end
                    else
                    begin
                        k_next     = '0;
                        state_next = ST_MAC;
                    end
                end
            end
            ST_MAC:
            begin
                cmd.mac_rd = 1'b1;
                if (k_reg == K_LAST)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                cmd.mic_update = 1'b1;
                state_next     = last_reg ? ST_EM1 : ST_IDLE;
            end
            ST_EM1:
            begin
                cmd.calc_m = 1'b1;
                state_next = ST_EM2;
            end
            ST_EM2:
            begin
                cmd.calc_mv = 1'b1;
                k_next      = '0;
                state_next  = ST_EP;
            end
            ST_EP:
            begin
                cmd.calc_p = 1'b1;
                state_next = ST_ECR;
            end
            ST_ECR:
            begin
                cmd.calc_cr = 1'b1;
                state_next  = ST_EDEC;
            end
            ST_EDEC:
            begin
                if (!status.candidate)
                begin
                    do_advance = 1'b1;
                end
                else if (!status.have)
                begin
                    cmd.take   = 1'b1;
                    do_advance = 1'b1;
                end
                else
                begin
                    step_next  = '0;
                    th_next    = 1'b0;
                    state_next = ST_MSTART;
                end
            end
            ST_MSTART:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_op    = th_reg ? th_op(step_reg) : cmp_op(step_reg);
                state_next    = ST_MWAIT;
            end
            ST_MWAIT:
            begin
                if (status.mul_done)
                begin
                    if (th_reg && (step_reg == TH_LAST_STEP))
                    begin
                        state_next = ST_TCMP;
                    end
                    else if (!th_reg && (step_reg == CMP_LAST_STEP))
                    begin
                        state_next = ST_ECMP;
                    end
                    else
                    begin
                        step_next  = step_reg + 1'b1;
                        state_next = ST_MSTART;
                    end
                end
            end
            ST_ECMP:
            begin
                cmd.take   = status.lhs_gt;
                do_advance = 1'b1;
            end
            ST_TCMP:
            begin
                found_next = status.lhs_ge;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.load_result  = 1'b1;
                    cmd.result_found = found_reg;
                    cmd.clear_acc    = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_advance)
        begin
            if (k_reg == K_LAST)
            begin
                if (status.have || cmd.take)
                begin
                    step_next  = '0;
                    th_next    = 1'b1;
                    state_next = ST_MSTART;
                end
                else
                begin
                    found_next = 1'b0;
                    state_next = ST_RESULT;
                end
            end
            else
            begin
                k_next     = k_reg + 1'b1;
                state_next = ST_EP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            k_reg     <= '0;
            step_reg  <= '0;
            th_reg    <= 1'b0;
            last_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            step_reg  <= step_next;
            th_reg    <= th_next;
            last_reg  <= last_next;
            found_reg <= found_next;
        end
    end

    `ZBRF_ASSERT_IMP(a_mul_start_idle, cmd.mul_start, !status.mul_busy)
    `ZBRF_ASSERT_IMP(a_load_when_free, cmd.load_result, status.out_free)
    `ZBRF_ASSERT_IMP(a_take_candidate, cmd.take, status.candidate)
    `ZBRF_ASSERT_NXT(a_start_then_wait, cmd.mul_start, status.mul_busy && !in_ready)

endmodule

@@ sim/zncc_best_reference_frame_test.sv @@
// ----------------------------------------------------------------------------
// Reference frame matcher testbench
// Drives reference writes and mic frames through the sample channel and
// scores every finished frame with an exact integer model of the correlation
// search. Each result word is checked against the oldest expected word. Both
// channels stall at random, and the threshold is changed between phases.
// ----------------------------------------------------------------------------
module zncc_best_reference_frame_test
    import zbrf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = 6;
    localparam int FRAME_LEN  = 512;
    localparam int CYCLE_CAP  = 3000000;
    localparam bit OP_WRITE   = 1'b0;
    localparam bit OP_MIC     = 1'b1;

    typedef struct packed {
        logic       found;
        logic [2:0] best_slot;
    } match_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [THR_W-1:0] cfg_wdata;

    zbrf_sample_if sample_ch ();
    zbrf_result_if result_ch ();

    zncc_best_reference_frame dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    logic signed [15:0] ref_frames [SLOTS*FRAME_LEN];
    longint mic_acc, mic_sq_acc;
    longint ref_acc [SLOTS];
    longint ref_sq_acc [SLOTS];
    longint cross_acc [SLOTS];
    int unsigned mic_count;
    logic [THR_W-1:0] threshold;

    match_t pending_matches [$];
    int errors;
    int words_sent;
    int matches_seen;
    int found_seen;
    int cycles;
    bit calm;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("zncc_best_reference_frame_test: FAIL");
            $finish;
        end
    end

    function automatic bit [255:0] sq_prod(bit [63:0] x, bit [63:0] y, bit [63:0] z);
        bit [255:0] a;
        a = x;
        a = a * x;
        a = a * y;
        a = a * z;
        return a;
    endfunction

    function automatic void clear_sums();
        mic_acc = 0;
        mic_sq_acc = 0;
        mic_count = 0;
        for (int k = 0; k < SLOTS; k++)
        begin
            ref_acc[k] = 0;
            ref_sq_acc[k] = 0;
            cross_acc[k] = 0;
        end
    endfunction

    function automatic void predict_word(bit op, logic [2:0] slot, logic [8:0] idx,
                                         logic signed [15:0] s, bit last);
        longint n, c, r;
        bit [63:0] m_var, r_var, ca, bc, bm, br;
        bit have;
        int best;
        match_t m;
        if (op == OP_WRITE)
        begin
            if (slot < SLOTS)
                ref_frames[slot*FRAME_LEN + idx] = s;
            return;
        end
        if (mic_count < FRAME_LEN)
        begin
            mic_acc += s;
            mic_sq_acc += longint'(s) * s;
            for (int k = 0; k < SLOTS; k++)
            begin
                r = ref_frames[k*FRAME_LEN + mic_count];
                ref_acc[k] += r;
                ref_sq_acc[k] += r * r;
                cross_acc[k] += longint'(s) * r;
            end
            mic_count++;
        end
        if (!last)
            return;
        n = mic_count;
        m_var = n * mic_sq_acc - mic_acc * mic_acc;
        have = 0;
        best = 0;
        bc = 0;
        bm = 0;
        br = 0;
        for (int k = 0; k < SLOTS; k++)
        begin
            c = n * cross_acc[k] - mic_acc * ref_acc[k];
            r_var = n * ref_sq_acc[k] - ref_acc[k] * ref_acc[k];
            ca = (c < 0) ? -c : c;
            if (m_var == 0 || r_var == 0 || ca == 0)
                continue;
            if (have && sq_prod(ca, bm, br) <= sq_prod(bc, m_var, r_var))
                continue;
            have = 1;
            best = k;
            bc = ca;
            bm = m_var;
            br = r_var;
        end
        m.found = have && (sq_prod(bc, 64'(PER_MILLE_SCALE), 1) >=
                           sq_prod(64'(threshold), bm, br));
        m.best_slot = m.found ? 3'(best) : 3'd0;
        pending_matches.push_back(m);
        clear_sums();
    endfunction

    task automatic send_word(bit op, logic [2:0] slot, logic [8:0] idx,
                             logic signed [15:0] s, bit last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.operation <= op;
        sample_ch.slot <= slot;
        sample_ch.sample_index <= idx;
        sample_ch.sample <= s;
        sample_ch.last <= last;
        do @(posedge clk); while (!sample_ch.ready);
        predict_word(op, slot, idx, s, last);
        words_sent++;
    endtask

    task automatic set_threshold(logic [THR_W-1:0] v);
        sample_ch.valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        threshold = v;
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] clamp16(int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return 16'(v);
    endfunction

    always
    begin
        int w;
        match_t got, want;
        w = calm ? 0 : $urandom_range(0, 8);
        if (w > 0)
        begin
            result_ch.ready <= 1'b0;
            repeat (w) @(posedge clk);
        end
        result_ch.ready <= 1'b1;
        do @(posedge clk); while (!result_ch.valid);
        got.found = result_ch.found;
        got.best_slot = result_ch.best_slot;
        matches_seen++;
        if (got.found)
            found_seen++;
        if (pending_matches.size() == 0)
        begin
            $display("%0t: unexpected result word found=%0d best_slot=%0d",
                     $time, got.found, got.best_slot);
            errors++;
        end
        else
        begin
            want = pending_matches.pop_front();
            if (got.found !== want.found)
            begin
                $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
                errors++;
            end
            if (got.best_slot !== want.best_slot)
            begin
                $display("%0t: best_slot expected %0d actual %0d",
                         $time, want.best_slot, got.best_slot);
                errors++;
            end
        end
    end

    task automatic test_empty_store();
        set_threshold(10'd0);
        for (int i = 0; i < 4; i++)
            send_word(OP_MIC, 3'($urandom), 9'($urandom), pick_sample(), i == 3);
        send_word(OP_MIC, 3'd7, 9'd511, 16'sd32767, 1'b1);
    endtask

    task automatic test_ties_and_threshold();
        for (int i = 0; i < 4; i++)
        begin
            send_word(OP_WRITE, 3'd0, 9'(i), 16'(i * 1000 - 1500), 1'b1);
            send_word(OP_WRITE, 3'd1, 9'(i), 16'(1500 - i * 1000), 1'b0);
        end
        send_word(OP_WRITE, 3'd6, 9'd0, -16'sd32768, 1'b0);
        send_word(OP_WRITE, 3'd7, 9'd511, 16'sd32767, 1'b1);
        set_threshold(10'd1000);
        for (int i = 0; i < 4; i++)
            send_word(OP_MIC, 3'd7, 9'd511, 16'(i * 7 - 10), i == 3);
        set_threshold(10'd999);
        send_word(OP_MIC, 3'd0, 9'd0, -16'sd32768, 1'b1);
        send_word(OP_MIC, 3'd0, 9'd0, 16'sd32767, 1'b0);
        send_word(OP_MIC, 3'd5, 9'd3, -16'sd32768, 1'b1);
    endtask

    task automatic test_random_frames();
        int len, src, gain;
        logic signed [15:0] s;
        while (words_sent < 1600 || matches_seen < 45)
        begin
            case ($urandom_range(0, 5))
                0: set_threshold(10'd0);
                1: set_threshold(10'd1000);
                2: set_threshold(10'($urandom_range(0, 1000)));
                default: ;
            endcase
            calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 30))
                send_word(OP_WRITE, ($urandom_range(0, 9) == 0) ? 3'($urandom) :
                          3'($urandom_range(0, SLOTS-1)),
                          ($urandom_range(0, 5) == 0) ? 9'($urandom) :
                          9'($urandom_range(0, 47)), pick_sample(), 1'($urandom));
            len = ($urandom_range(0, 24) == 0) ? $urandom_range(505, 520) :
                  $urandom_range(1, 40);
            src = $urandom_range(0, SLOTS);
            gain = $urandom_range(0, 6) - 3;
            for (int i = 0; i < len; i++)
            begin
                if (src < SLOTS && i < FRAME_LEN && $urandom_range(0, 3) != 0)
                    s = clamp16(ref_frames[src*FRAME_LEN + i] * gain +
                                int'($urandom_range(0, 400)) - 200);
                else
                    s = pick_sample();
                send_word(OP_MIC, 3'($urandom), 9'($urandom), s, i == len - 1);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        sample_ch.valid = 1'b0;
        sample_ch.operation = OP_WRITE;
        sample_ch.slot = '0;
        sample_ch.sample_index = '0;
        sample_ch.sample = '0;
        sample_ch.last = 1'b0;
        errors = 0;
        words_sent = 0;
        matches_seen = 0;
        found_seen = 0;
        calm = 0;
        threshold = THR_RESET;
        for (int i = 0; i < SLOTS*FRAME_LEN; i++)
            ref_frames[i] = '0;
        clear_sums();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_store();
        test_ties_and_threshold();
        test_random_frames();
        sample_ch.valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Sent %0d sample words; checked %0d result words, %0d of them matches.",
                 words_sent, matches_seen, found_seen);
        if (errors == 0 && pending_matches.size() == 0)
            $display("zncc_best_reference_frame_test: PASS");
        else
            $display("zncc_best_reference_frame_test: FAIL");
        $finish;
    end
endmodule
